>>> rtl/ggv_pkg.sv
// Shared types, constants and helpers of the granular grain voice.
package ggv_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int LENGTH_BITS_DEF = 24;
  localparam int CFG_DATA_W      = 40;
  localparam int CFG_INDEX_W     = 3;
  localparam int POS_W           = 40;
  localparam int MIX_W           = 24;
  localparam int STEP_W          = 24;
  localparam int GAIN_W          = 16;
  localparam int MUL_W           = 32;
  localparam int PROD_W          = 64;
  localparam int PH_W            = 17;
  localparam int CONTRIB_W       = 27;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SHAPE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRAIN_LENGTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRAIN_GAIN    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PLAYBACK_STEP = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_POS     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STEREO        = 3'd5;

  // Window shapes and operations.
  localparam logic [1:0] SHAPE_HANN  = 2'd0;
  localparam logic [1:0] SHAPE_GAUSS = 2'd1;
  localparam logic [1:0] SHAPE_TRAP  = 2'd2;
  localparam logic       OP_TICK     = 1'b0;
  localparam logic       OP_START    = 1'b1;

  // Fixed-point constants (Q30 series coefficients, Q16 window).
  localparam logic [MUL_W-1:0] Q30_ONE = 32'd1073741824;
  localparam logic [MUL_W-1:0] SIN_C1  = 32'd1686629713;
  localparam logic [MUL_W-1:0] SIN_C3  = 32'd693598668;
  localparam logic [MUL_W-1:0] SIN_C5  = 32'd85569305;
  localparam logic [MUL_W-1:0] SIN_C7  = 32'd5026995;
  localparam logic [MUL_W-1:0] SIN_C9  = 32'd172272;
  // Reciprocals for floor(x/5) and floor(x/3) as (x*M)>>32, exact for x < 2^30.
  localparam logic [MUL_W-1:0] RECIP5  = 32'd858993460;
  localparam logic [MUL_W-1:0] RECIP3  = 32'd1431655766;
  localparam logic [PH_W-1:0]  W_ONE   = 17'd65536;
  localparam logic [PH_W-1:0]  PH_HALF = 17'd32768;
  localparam logic [PH_W-1:0]  TRAP_LO = 17'd6553;
  localparam logic [PH_W-1:0]  TRAP_HI = 17'd58983;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_SHAPE,
    ST_H_Z, ST_H_T9, ST_H_T7, ST_H_T5, ST_H_T3, ST_H_T1, ST_H_S, ST_H_W,
    ST_G_R, ST_G_E5, ST_G_E4, ST_G_E3M, ST_G_E3, ST_G_E2, ST_G_E1,
    ST_G_SQ1, ST_G_SQ2, ST_G_SQ3, ST_G_W,
    ST_C_GW, ST_C_L, ST_C_R, ST_C_OUT
  } state_t;

  // Saturate a widened mix sum to the 24-bit signed range.
  function automatic logic [MIX_W-1:0] sat_mix(input logic signed [CONTRIB_W-1:0] v);
    logic [MIX_W-1:0] res;
    if (v > $signed(27'sd8388607)) begin
      res = 24'h7FFFFF;
    end else if (v < $signed(-27'sd8388608)) begin
      res = 24'h800000;
    end else begin
      res = v[MIX_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/ggv_mul.sv
// Shared 32x32 multiplier with registered product.
module ggv_mul (
  input  logic                         clk,
  input  logic [ggv_pkg::MUL_W-1:0]    mul_a,
  input  logic [ggv_pkg::MUL_W-1:0]    mul_b,
  output logic [ggv_pkg::PROD_W-1:0]   prod
);

  logic [ggv_pkg::PROD_W-1:0] prod_r;

  // One product per cycle; the sequencer picks up the registered result in the next cycle.
  always_ff @(posedge clk) begin
    prod_r <= ggv_pkg::PROD_W'(mul_a) * ggv_pkg::PROD_W'(mul_b);
  end

  assign prod = prod_r;

endmodule

>>> rtl/ggv_div.sv
// Bit-serial divider giving floor(num * 2^16 / den) for num < den.
module ggv_div #(
  parameter int LENGTH_BITS = ggv_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [LENGTH_BITS-1:0] num,
  input  logic [LENGTH_BITS-1:0] den,
  output logic                   done,
  output logic [15:0]            quot
);

  logic [LENGTH_BITS:0]   rem_r;
  logic [LENGTH_BITS-1:0] den_r;
  logic [15:0]            quot_r;
  logic [3:0]             cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic [LENGTH_BITS:0]   rem_sh;
  logic                   fits;

  // One quotient bit per cycle by restoring subtraction.
  assign rem_sh = {rem_r[LENGTH_BITS-1:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
    end else if (busy_r) begin
      rem_r  <= fits ? rem_sh - {1'b0, den_r} : rem_sh;
      quot_r <= {quot_r[14:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

>>> rtl/granular_grain_voice.sv
// Top level of the granular grain voice: config, sequencer and output register.
// Start items and idle ticks give their beat in the cycle after acceptance. An active tick
// passes through the phase divider, the shape state, then the shared multiplier passes of
// its window and its contribution; trapezoid skips the series, a clamped phase skips the
// divider and a one-sample grain skips divider, shape and series. Output stalls hold the beat.
// Throughput: one item at a time, input stalls while busy. Reset: synchronous rst_n, defaults.
module granular_grain_voice #(
  parameter int SAMPLE_BITS = ggv_pkg::SAMPLE_BITS_DEF,
  parameter int LENGTH_BITS = ggv_pkg::LENGTH_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_operation,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample_left,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample_right,
  input  logic signed [ggv_pkg::MIX_W-1:0]   in_mix_in_left,
  input  logic signed [ggv_pkg::MIX_W-1:0]   in_mix_in_right,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ggv_pkg::MIX_W-1:0]   out_mix_left,
  output logic signed [ggv_pkg::MIX_W-1:0]   out_mix_right,
  output logic [ggv_pkg::POS_W-1:0]          out_fetch_position,
  output logic                               out_still_active,
  input  logic                               cfg_we,
  input  logic [ggv_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ggv_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SH = 14 + SAMPLE_BITS;
  localparam int CW = ggv_pkg::CONTRIB_W;

  ggv_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [1:0]                   shape_r;
  logic [LENGTH_BITS-1:0]       length_r;
  logic [ggv_pkg::GAIN_W-1:0]   gain_r;
  logic [ggv_pkg::STEP_W-1:0]   step_r;
  logic [ggv_pkg::POS_W-1:0]    start_pos_r;
  logic                         stereo_r;

  // Grain state.
  logic [ggv_pkg::POS_W-1:0]    pos_r;
  logic [LENGTH_BITS-1:0]       count_r;
  logic                         active_r;

  // Captured item and working registers.
  logic signed [SAMPLE_BITS-1:0]     samp_l_r, samp_r_r;
  logic signed [ggv_pkg::MIX_W-1:0]  mix_l_r, mix_r_r;
  logic [ggv_pkg::PH_W-1:0]          ph_r, w_r;
  logic [ggv_pkg::MUL_W-1:0]         u_r, z_r, r_r, gw_r;
  logic signed [CW-1:0]              cl_r;

  // Output register.
  logic                              out_valid_r;
  logic [ggv_pkg::MIX_W-1:0]         out_l_r, out_r_r;
  logic [ggv_pkg::POS_W-1:0]         out_pos_r;
  logic                              out_act_r;

  logic                              in_acc;
  logic                              out_busy;
  logic [LENGTH_BITS-1:0]            len_eff, den;
  logic                              len_one, ph_clamp;
  logic                              div_start, div_done;
  logic [15:0]                       div_q;
  logic [ggv_pkg::MUL_W-1:0]         mul_a, mul_b;
  logic [ggv_pkg::PROD_W-1:0]        prod;
  logic [ggv_pkg::MUL_W-1:0]         q30, q32;
  logic [ggv_pkg::PH_W-1:0]          ph_fold, ph_dist, trap_w;
  logic [SAMPLE_BITS-1:0]            mag_l, mag_r;
  logic [ggv_pkg::PROD_W-1:0]        rnd;
  logic [CW-2:0]                     cmag;
  logic signed [CW-1:0]              c_new, cr;
  logic [ggv_pkg::MUL_W:0]           wsum;
  logic [18:0]                       wq;
  logic [LENGTH_BITS:0]              count_inc;

  assign out_busy = out_valid_r && out_stall;
  assign in_stall = (state_r != ggv_pkg::ST_IDLE) || out_busy;
  assign in_acc   = in_valid && !in_stall;

  assign len_eff  = (length_r == '0) ? LENGTH_BITS'(1) : length_r;
  assign den      = len_eff - LENGTH_BITS'(1);
  assign len_one  = (len_eff == LENGTH_BITS'(1));
  assign ph_clamp = (count_r >= den);
  assign count_inc = {1'b0, count_r} + (LENGTH_BITS+1)'(1);

  // Product views: Q30 floor and the >>32 of the reciprocal trick.
  assign q30 = prod[61:30];
  assign q32 = prod[63:32];

  assign ph_fold = (ph_r <= ggv_pkg::PH_HALF) ? ph_r : ggv_pkg::W_ONE - ph_r;
  assign ph_dist = (ph_r >= ggv_pkg::PH_HALF) ? ph_r - ggv_pkg::PH_HALF
                                              : ggv_pkg::PH_HALF - ph_r;

  // Trapezoid window: linear ramps over the first and last tenth.
  always_comb begin
    if (ph_r <= ggv_pkg::TRAP_LO) begin
      trap_w = ggv_pkg::PH_W'(ph_r * 17'd10);
    end else if (ph_r >= ggv_pkg::TRAP_HI) begin
      trap_w = ggv_pkg::PH_W'((ggv_pkg::W_ONE - ph_r) * 17'd10);
    end else begin
      trap_w = ggv_pkg::W_ONE;
    end
  end

  // Final rounding of a Q30 window to Q16 with clamp at one.
  assign wsum = {1'b0, q30} + 33'd8192;
  assign wq   = wsum[32:14];

  // Sample magnitudes and the rounded contribution of the current product.
  assign mag_l = samp_l_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-samp_l_r) : samp_l_r;
  assign mag_r = samp_r_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-samp_r_r) : samp_r_r;
  assign rnd   = prod + (ggv_pkg::PROD_W'(1) << (SH - 1));
  assign cmag  = (CW-1)'(rnd >> SH);

  always_comb begin
    if (state_r == ggv_pkg::ST_C_R) begin
      c_new = samp_l_r[SAMPLE_BITS-1] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
    end else begin
      c_new = samp_r_r[SAMPLE_BITS-1] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
    end
  end
  assign cr = stereo_r ? c_new : cl_r;

  ggv_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  ggv_div #(.LENGTH_BITS(LENGTH_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (count_r),
    .den   (den),
    .done  (div_done),
    .quot  (div_q)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ggv_pkg::ST_IDLE: begin
        if (in_acc && in_operation == ggv_pkg::OP_TICK && active_r) begin
          if (len_one) begin
            state_nxt = ggv_pkg::ST_C_GW;
          end else if (ph_clamp) begin
            state_nxt = ggv_pkg::ST_SHAPE;
          end else begin
            state_nxt = ggv_pkg::ST_DIV;
          end
        end
      end
      ggv_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = ggv_pkg::ST_SHAPE;
        end
      end
      ggv_pkg::ST_SHAPE: begin
        if (shape_r == ggv_pkg::SHAPE_HANN) begin
          state_nxt = ggv_pkg::ST_H_Z;
        end else if (shape_r == ggv_pkg::SHAPE_GAUSS) begin
          state_nxt = ggv_pkg::ST_G_R;
        end else begin
          state_nxt = ggv_pkg::ST_C_GW;
        end
      end
      ggv_pkg::ST_H_Z:   state_nxt = ggv_pkg::ST_H_T9;
      ggv_pkg::ST_H_T9:  state_nxt = ggv_pkg::ST_H_T7;
      ggv_pkg::ST_H_T7:  state_nxt = ggv_pkg::ST_H_T5;
      ggv_pkg::ST_H_T5:  state_nxt = ggv_pkg::ST_H_T3;
      ggv_pkg::ST_H_T3:  state_nxt = ggv_pkg::ST_H_T1;
      ggv_pkg::ST_H_T1:  state_nxt = ggv_pkg::ST_H_S;
      ggv_pkg::ST_H_S:   state_nxt = ggv_pkg::ST_H_W;
      ggv_pkg::ST_H_W:   state_nxt = ggv_pkg::ST_C_GW;
      ggv_pkg::ST_G_R:   state_nxt = ggv_pkg::ST_G_E5;
      ggv_pkg::ST_G_E5:  state_nxt = ggv_pkg::ST_G_E4;
      ggv_pkg::ST_G_E4:  state_nxt = ggv_pkg::ST_G_E3M;
      ggv_pkg::ST_G_E3M: state_nxt = ggv_pkg::ST_G_E3;
      ggv_pkg::ST_G_E3:  state_nxt = ggv_pkg::ST_G_E2;
      ggv_pkg::ST_G_E2:  state_nxt = ggv_pkg::ST_G_E1;
      ggv_pkg::ST_G_E1:  state_nxt = ggv_pkg::ST_G_SQ1;
      ggv_pkg::ST_G_SQ1: state_nxt = ggv_pkg::ST_G_SQ2;
      ggv_pkg::ST_G_SQ2: state_nxt = ggv_pkg::ST_G_SQ3;
      ggv_pkg::ST_G_SQ3: state_nxt = ggv_pkg::ST_G_W;
      ggv_pkg::ST_G_W:   state_nxt = ggv_pkg::ST_C_GW;
      ggv_pkg::ST_C_GW:  state_nxt = ggv_pkg::ST_C_L;
      ggv_pkg::ST_C_L:   state_nxt = ggv_pkg::ST_C_R;
      ggv_pkg::ST_C_R:   state_nxt = ggv_pkg::ST_C_OUT;
      ggv_pkg::ST_C_OUT: begin
        if (!out_busy) begin
          state_nxt = ggv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ggv_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands and divider launch.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_r)
      ggv_pkg::ST_IDLE: begin
        div_start = in_acc && in_operation == ggv_pkg::OP_TICK && active_r &&
                    !len_one && !ph_clamp;
      end
      ggv_pkg::ST_H_Z: begin
        mul_a = u_r;
        mul_b = u_r;
      end
      ggv_pkg::ST_H_T9: begin
        mul_a = q30;
        mul_b = ggv_pkg::SIN_C9;
      end
      ggv_pkg::ST_H_T7: begin
        mul_a = z_r;
        mul_b = ggv_pkg::SIN_C7 - q30;
      end
      ggv_pkg::ST_H_T5: begin
        mul_a = z_r;
        mul_b = ggv_pkg::SIN_C5 - q30;
      end
      ggv_pkg::ST_H_T3: begin
        mul_a = z_r;
        mul_b = ggv_pkg::SIN_C3 - q30;
      end
      ggv_pkg::ST_H_T1: begin
        mul_a = u_r;
        mul_b = ggv_pkg::SIN_C1 - q30;
      end
      ggv_pkg::ST_H_S: begin
        mul_a = q30;
        mul_b = q30;
      end
      ggv_pkg::ST_G_R: begin
        mul_a = ggv_pkg::MUL_W'(ph_dist);
        mul_b = ggv_pkg::MUL_W'(ph_dist);
      end
      ggv_pkg::ST_G_E5: begin
        mul_a = prod[33:2];
        mul_b = ggv_pkg::RECIP5;
      end
      ggv_pkg::ST_G_E4: begin
        mul_a = r_r;
        mul_b = ggv_pkg::Q30_ONE - q32;
      end
      ggv_pkg::ST_G_E3M: begin
        mul_a = r_r;
        mul_b = ggv_pkg::Q30_ONE - (q30 >> 2);
      end
      ggv_pkg::ST_G_E3: begin
        mul_a = q30;
        mul_b = ggv_pkg::RECIP3;
      end
      ggv_pkg::ST_G_E2: begin
        mul_a = r_r;
        mul_b = ggv_pkg::Q30_ONE - q32;
      end
      ggv_pkg::ST_G_E1: begin
        mul_a = r_r;
        mul_b = ggv_pkg::Q30_ONE - (q30 >> 1);
      end
      ggv_pkg::ST_G_SQ1: begin
        mul_a = ggv_pkg::Q30_ONE - q30;
        mul_b = ggv_pkg::Q30_ONE - q30;
      end
      ggv_pkg::ST_G_SQ2, ggv_pkg::ST_G_SQ3: begin
        mul_a = q30;
        mul_b = q30;
      end
      ggv_pkg::ST_C_GW: begin
        mul_a = ggv_pkg::MUL_W'(gain_r);
        mul_b = ggv_pkg::MUL_W'(w_r);
      end
      ggv_pkg::ST_C_L: begin
        mul_a = prod[31:0];
        mul_b = ggv_pkg::MUL_W'(mag_l);
      end
      ggv_pkg::ST_C_R: begin
        mul_a = gw_r;
        mul_b = ggv_pkg::MUL_W'(mag_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Control registers: state, configuration, grain state, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ggv_pkg::ST_IDLE;
      shape_r     <= ggv_pkg::SHAPE_HANN;
      length_r    <= LENGTH_BITS'(1);
      gain_r      <= 16'd16384;
      step_r      <= 24'd65536;
      start_pos_r <= '0;
      stereo_r    <= 1'b1;
      pos_r       <= '0;
      count_r     <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ggv_pkg::REG_WINDOW_SHAPE:  shape_r     <= cfg_data[1:0];
          ggv_pkg::REG_GRAIN_LENGTH:  length_r    <= cfg_data[LENGTH_BITS-1:0];
          ggv_pkg::REG_GRAIN_GAIN:    gain_r      <= cfg_data[ggv_pkg::GAIN_W-1:0];
          ggv_pkg::REG_PLAYBACK_STEP: step_r      <= cfg_data[ggv_pkg::STEP_W-1:0];
          ggv_pkg::REG_START_POS:     start_pos_r <= cfg_data[ggv_pkg::POS_W-1:0];
          ggv_pkg::REG_STEREO:        stereo_r    <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      // Start items and idle ticks finish in the accept cycle.
      if (in_acc) begin
        if (in_operation == ggv_pkg::OP_START) begin
          pos_r       <= start_pos_r;
          count_r     <= '0;
          active_r    <= 1'b1;
          out_valid_r <= 1'b1;
        end else if (!active_r) begin
          out_valid_r <= 1'b1;
        end
      end
      // A rendered tick advances the grain when its beat is loaded.
      if (state_r == ggv_pkg::ST_C_OUT && !out_busy) begin
        pos_r       <= pos_r + ggv_pkg::POS_W'(step_r);
        count_r     <= count_inc[LENGTH_BITS-1:0];
        active_r    <= !(count_inc >= {1'b0, len_eff});
        out_valid_r <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_l_r <= in_sample_left;
      samp_r_r <= in_sample_right;
      mix_l_r  <= in_mix_in_left;
      mix_r_r  <= in_mix_in_right;
      if (in_operation == ggv_pkg::OP_START) begin
        out_l_r   <= '0;
        out_r_r   <= '0;
        out_pos_r <= start_pos_r;
        out_act_r <= 1'b1;
      end else if (!active_r) begin
        out_l_r   <= '0;
        out_r_r   <= '0;
        out_pos_r <= '0;
        out_act_r <= 1'b0;
      end
      if (len_one) begin
        w_r <= ggv_pkg::W_ONE;
      end
      if (ph_clamp) begin
        ph_r <= ggv_pkg::W_ONE;
      end
    end
    if (state_r == ggv_pkg::ST_DIV && div_done) begin
      ph_r <= {1'b0, div_q};
    end
    if (state_r == ggv_pkg::ST_SHAPE) begin
      u_r <= ggv_pkg::MUL_W'({ph_fold, 15'd0});
      if (shape_r == ggv_pkg::SHAPE_TRAP) begin
        w_r <= trap_w;
      end else begin
        w_r <= ggv_pkg::W_ONE;
      end
    end
    if (state_r == ggv_pkg::ST_H_T9) begin
      z_r <= q30;
    end
    if (state_r == ggv_pkg::ST_G_E5) begin
      r_r <= prod[33:2];
    end
    if (state_r == ggv_pkg::ST_H_W || state_r == ggv_pkg::ST_G_W) begin
      w_r <= (wq > 19'd65536) ? ggv_pkg::W_ONE : wq[ggv_pkg::PH_W-1:0];
    end
    if (state_r == ggv_pkg::ST_C_L) begin
      gw_r <= prod[31:0];
    end
    if (state_r == ggv_pkg::ST_C_R) begin
      cl_r <= c_new;
    end
    if (state_r == ggv_pkg::ST_C_OUT && !out_busy) begin
      out_l_r   <= ggv_pkg::sat_mix(CW'(mix_l_r) + cl_r);
      out_r_r   <= ggv_pkg::sat_mix(CW'(mix_r_r) + cr);
      out_pos_r <= pos_r + ggv_pkg::POS_W'(step_r);
      out_act_r <= !(count_inc >= {1'b0, len_eff});
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mix_left       = out_l_r;
  assign out_mix_right      = out_r_r;
  assign out_fetch_position = out_pos_r;
  assign out_still_active   = out_act_r;

endmodule
